// File: design/first_primes_generator_assert.svh
// ----------------------------------------------------------------------------
// First primes generator assertion macros
// Shared concurrent assertion forms for the generator and its remainder unit.
// ----------------------------------------------------------------------------
`ifndef FIRST_PRIMES_GENERATOR_ASSERT_SVH
`define FIRST_PRIMES_GENERATOR_ASSERT_SVH

// check the consequent in the same cycle as the antecedent
`define FPG_ASSERT_SAME(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// check the consequent in the cycle after the antecedent
`define FPG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/fpg_pkg.sv
// ----------------------------------------------------------------------------
// First primes generator package
// Field widths, trial division constants and the remainder unit interface.
// ----------------------------------------------------------------------------
`default_nettype none

package fpg_pkg;

   localparam int COUNT_W = 7;
   localparam int PRIME_W = 9;
   localparam int POS_W   = 6;
   localparam int DIV_W   = 5;
   localparam int SQ_W    = 10;
   localparam int STEP_W  = $clog2(PRIME_W);

   localparam logic [PRIME_W-1:0] CAND_START = PRIME_W'(2);
   localparam logic [DIV_W-1:0]   DIV_START  = DIV_W'(2);
   localparam logic [SQ_W-1:0]    SQ_START   = SQ_W'(4);
   localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(PRIME_W - 1);

   typedef struct packed {
      logic               start;
      logic [PRIME_W-1:0] dividend;
      logic [DIV_W-1:0]   divisor;
   } rem_req_type;

   typedef struct packed {
      logic             done;
      logic [DIV_W-1:0] rem;
   } rem_rsp_type;

endpackage

`default_nettype wire

// File: design/first_primes_generator.sv
// ----------------------------------------------------------------------------
// First primes generator
// Emits the first count primes (count capped at MAX_COUNT) in ascending order, found by trial division.
//
//   channel   dir   handshake          payload
//   req_      in    valid / stall      count
//   rsp_      out   valid / stall      prime_value, position, last
//
// Each trial division is one test, nine remainder steps and one result.
// A composite costs one trial division per divisor tried; a prime adds one final
// test and a load of the result register.
// req_stall stays high until the last result is loaded. Reset is synchronous and
// clears all control. A stalled result holds the search at the next prime found.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_primes_generator_assert.svh"

module first_primes_generator
   import fpg_pkg::*;
#(
   parameter int MAX_COUNT = 64
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [COUNT_W-1:0] req_count,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [PRIME_W-1:0]      rsp_prime_value,
   output logic [POS_W-1:0]        rsp_position,
   output logic                    rsp_last
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_TEST = 2'd1;
   localparam logic [1:0] S_DIV  = 2'd2;
   localparam logic [1:0] S_EMIT = 2'd3;

   localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(MAX_COUNT);

   logic [1:0]          state_ff, state_in;
   logic [COUNT_W-1:0]  want_ff, want_in;
   logic [COUNT_W-1:0]  found_ff, found_in;
   logic [PRIME_W-1:0]  cand_ff, cand_in;
   logic [DIV_W-1:0]    div_ff, div_in;
   logic [SQ_W-1:0]     sq_ff, sq_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [PRIME_W-1:0]  rsp_prime_ff, rsp_prime_in;
   logic [POS_W-1:0]    rsp_pos_ff, rsp_pos_in;
   logic                rsp_last_ff, rsp_last_in;

   logic [COUNT_W-1:0]  req_want;
   logic [COUNT_W-1:0]  found_inc;
   logic                out_free;
   logic                is_last;
   logic                load;
   rem_req_type         rem_req;
   rem_rsp_type         rem_rsp;

   fpg_rem u_rem (
      .clock   (clock),
      .reset   (reset),
      .rem_req (rem_req),
      .rem_rsp (rem_rsp)
   );

   assign req_want  = (req_count > COUNT_MAX) ? COUNT_MAX : req_count;
   assign found_inc = COUNT_W'(found_ff + 1'b1);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign is_last   = (found_inc == want_ff);
   assign load      = (state_ff == S_EMIT) && out_free;

   assign rem_req.start    = (state_ff == S_TEST) && (sq_ff <= {1'b0, cand_ff});
   assign rem_req.dividend = cand_ff;
   assign rem_req.divisor  = div_ff;

   always_comb begin
      state_in     = state_ff;
      want_in      = want_ff;
      found_in     = found_ff;
      cand_in      = cand_ff;
      div_in       = div_ff;
      sq_in        = sq_ff;
      rsp_prime_in = rsp_prime_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               want_in  = req_want;
               found_in = '0;
               cand_in  = CAND_START;
               div_in   = DIV_START;
               sq_in    = SQ_START;
               if (req_want != '0) begin
                  state_in = S_TEST;
               end
            end
         end
         S_TEST: begin
            if (sq_ff > {1'b0, cand_ff}) begin
               state_in = S_EMIT;
            end else begin
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            if (rem_rsp.done) begin
               state_in = S_TEST;
               if (rem_rsp.rem == '0) begin
                  cand_in = PRIME_W'(cand_ff + 1'b1);
                  div_in  = DIV_START;
                  sq_in   = SQ_START;
               end else begin
                  div_in = DIV_W'(div_ff + 1'b1);
                  sq_in  = SQ_W'(sq_ff + {SQ_W'(div_ff), 1'b1});
               end
            end
         end
         S_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_prime_in = cand_ff;
               rsp_pos_in   = found_ff[POS_W-1:0];
               rsp_last_in  = is_last;
               found_in     = found_inc;
               cand_in      = PRIME_W'(cand_ff + 1'b1);
               div_in       = DIV_START;
               sq_in        = SQ_START;
               state_in     = is_last ? S_IDLE : S_TEST;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      want_ff      <= want_in;
      found_ff     <= found_in;
      cand_ff      <= cand_in;
      div_ff       <= div_in;
      sq_ff        <= sq_in;
      rsp_prime_ff <= rsp_prime_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign req_stall       = (state_ff != S_IDLE);
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_prime_value = rsp_prime_ff;
   assign rsp_position    = rsp_pos_ff;
   assign rsp_last        = rsp_last_ff;

   `FPG_ASSERT_SAME(a_done_in_div, clock, reset, rem_rsp.done, state_ff == S_DIV, "stray done")
   `FPG_ASSERT_SAME(a_square_track, clock, reset, state_ff == S_TEST,
      sq_ff == SQ_W'(SQ_W'(div_ff) * SQ_W'(div_ff)), "divisor square out of step")
   `FPG_ASSERT_NEXT(a_hold_on_stall, clock, reset,
      (state_ff == S_EMIT) && rsp_valid_ff && rsp_stall, $stable(found_ff), "emit under stall")
   `FPG_ASSERT_NEXT(a_load_valid, clock, reset, load, rsp_valid_ff, "loaded result not shown")

endmodule

`default_nettype wire

// File: design/fpg_rem.sv
// ----------------------------------------------------------------------------
// First primes generator remainder unit
// Restoring bit-serial remainder, one dividend bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
`include "first_primes_generator_assert.svh"

module fpg_rem
   import fpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire rem_req_type rem_req,
   output rem_rsp_type      rem_rsp
);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [PRIME_W-1:0]  dvd_ff, dvd_in;
   logic [DIV_W-1:0]    dvs_ff, dvs_in;
   logic [DIV_W-1:0]    part_ff, part_in;
   logic [DIV_W:0]      shifted;

   assign shifted = {part_ff, dvd_ff[PRIME_W-1]};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      dvd_in  = dvd_ff;
      dvs_in  = dvs_ff;
      part_in = part_ff;
      if (rem_req.start) begin
         busy_in = 1'b1;
         step_in = '0;
         dvd_in  = rem_req.dividend;
         dvs_in  = rem_req.divisor;
         part_in = '0;
      end else if (busy_ff) begin
         dvd_in = {dvd_ff[PRIME_W-2:0], 1'b0};
         if (shifted >= {1'b0, dvs_ff}) begin
            part_in = DIV_W'(shifted - {1'b0, dvs_ff});
         end else begin
            part_in = shifted[DIV_W-1:0];
         end
         step_in = STEP_W'(step_ff + 1'b1);
         if (step_ff == LAST_STEP) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      dvd_ff  <= dvd_in;
      dvs_ff  <= dvs_in;
      part_ff <= part_in;
   end

   assign rem_rsp.done = done_ff;
   assign rem_rsp.rem  = part_ff;

   `FPG_ASSERT_SAME(a_start_idle, clock, reset, rem_req.start, !busy_ff, "start while busy")
   `FPG_ASSERT_SAME(a_done_idle, clock, reset, done_ff, !busy_ff, "done while busy")

endmodule

`default_nettype wire

// File: verif/first_primes_generator_checker.sv
// ----------------------------------------------------------------------------
// First primes generator checker
// Watches the request and response channels, predicts the primes of every
// accepted count by trial division and compares each response transfer,
// field by field, with the oldest predicted prime.
// ----------------------------------------------------------------------------
module first_primes_generator_checker
   import fpg_pkg::*;
#(
   parameter int MAX_COUNT = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [COUNT_W-1:0] req_count,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [PRIME_W-1:0] rsp_prime_value,
   input  logic [POS_W-1:0]   rsp_position,
   input  logic               rsp_last,
   output int                 mismatches,
   output int                 primes_pending
);

   typedef struct packed {
      logic [PRIME_W-1:0] prime_value;
      logic [POS_W-1:0]   position;
      logic               last;
   } prime_result_type;

   prime_result_type expected_primes[$];

   initial begin
      mismatches     = 0;
      primes_pending = 0;
   end

   function automatic bit divides_none(input int unsigned cand);
      for (int unsigned d = 2; d * d <= cand; d++) begin
         if (cand % d == 0) return 1'b0;
      end
      return cand >= 2;
   endfunction

   task automatic predict_primes(input logic [COUNT_W-1:0] count);
      int unsigned      want;
      int unsigned      found;
      int unsigned      cand;
      prime_result_type entry;
      want  = (int'(count) > MAX_COUNT) ? MAX_COUNT : int'(count);
      found = 0;
      cand  = 2;
      while (found < want) begin
         if (divides_none(cand)) begin
            entry.prime_value = PRIME_W'(cand);
            entry.position    = POS_W'(found);
            entry.last        = (found + 1 == want);
            expected_primes.push_back(entry);
            found++;
         end
         cand++;
      end
   endtask

   always @(posedge clock) begin
      prime_result_type exp_prime;
      if (!reset) begin
         if (req_valid && !req_stall) predict_primes(req_count);
         if (rsp_valid && !rsp_stall) begin
            if (expected_primes.size() == 0) begin
               $error("unexpected rsp transfer: prime_value %0d position %0d last %0d",
                      rsp_prime_value, rsp_position, rsp_last);
               mismatches <= mismatches + 1;
            end else begin
               exp_prime = expected_primes.pop_front();
               if (rsp_prime_value !== exp_prime.prime_value ||
                   rsp_position !== exp_prime.position ||
                   rsp_last !== exp_prime.last) begin
                  if (rsp_prime_value !== exp_prime.prime_value)
                     $error("prime_value: expected %0d, got %0d",
                            exp_prime.prime_value, rsp_prime_value);
                  if (rsp_position !== exp_prime.position)
                     $error("position: expected %0d, got %0d",
                            exp_prime.position, rsp_position);
                  if (rsp_last !== exp_prime.last)
                     $error("last: expected %0d, got %0d", exp_prime.last, rsp_last);
                  mismatches <= mismatches + 1;
               end
            end
         end
         primes_pending <= expected_primes.size();
      end
   end

endmodule

// File: verif/tb_first_primes_generator.sv
// ----------------------------------------------------------------------------
// First primes generator testbench
// Drives directed and random counts in bursts against a randomly stalling
// receiver, including one long receiver hold-off and two full drains, and
// reports the verdict from the checker's mismatch and pending counts.
// ----------------------------------------------------------------------------
module tb_first_primes_generator;
   import fpg_pkg::*;

   localparam int MAX_COUNT    = 64;
   localparam int RANDOM_ITEMS = 144;
   localparam int LONG_HOLD    = 400;
   localparam int TAIL_CYCLES  = 200;
   localparam int DIRECTED_COUNTS [16] = '{0, 1, 2, 3, 4, 5, 10, 0, 63, 64, 65, 127, 100,
                                            1, 32, 16};

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [COUNT_W-1:0] req_count;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [PRIME_W-1:0] rsp_prime_value;
   logic [POS_W-1:0]   rsp_position;
   logic               rsp_last;
   int                 mismatches;
   int                 primes_pending;
   int                 hold_requests = 0;
   int                 holds_done = 0;
   int unsigned        burst_left = 0;

   always #5 clock = ~clock;

   first_primes_generator #(
      .MAX_COUNT(MAX_COUNT)
   ) DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_value(rsp_prime_value),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last)
   );

   first_primes_generator_checker #(
      .MAX_COUNT(MAX_COUNT)
   ) checker_i (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_count      (req_count),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_prime_value(rsp_prime_value),
      .rsp_position   (rsp_position),
      .rsp_last       (rsp_last),
      .mismatches     (mismatches),
      .primes_pending (primes_pending)
   );

   function automatic logic [COUNT_W-1:0] random_count();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      if (pick < 7) return COUNT_W'($urandom_range(0, 16));
      else if (pick < 9) return COUNT_W'($urandom_range(17, 64));
      else return COUNT_W'($urandom_range(65, 127));
   endfunction

   // offer one count, opening a new burst after a random gap when due
   task automatic transfer_count(input logic [COUNT_W-1:0] count);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_valid <= 1'b0;
            req_count <= COUNT_W'($urandom);
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_count <= count;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_primes();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(posedge clock); while (primes_pending != 0);
   endtask

   initial begin
      int unsigned mode;
      int unsigned span;
      int unsigned phase;
      rsp_stall = 1'b0;
      forever begin
         mode = $urandom_range(0, 3);
         span = $urandom_range(16, 160);
         for (phase = 0; phase < span; phase++) begin
            @(posedge clock);
            if (holds_done != hold_requests) begin
               rsp_stall <= 1'b1;
               repeat (LONG_HOLD) @(posedge clock);
               holds_done++;
            end else begin
               case (mode)
                  0: rsp_stall <= 1'b0;
                  1: rsp_stall <= ($urandom_range(0, 3) == 0);
                  2: rsp_stall <= (phase % 3 == 0);
                  default: rsp_stall <= $urandom_range(0, 1);
               endcase
            end
         end
      end
   end

   initial begin
      reset     = 1'b1;
      req_valid = 1'b0;
      req_count = '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      for (int i = 0; i < $size(DIRECTED_COUNTS); i++)
         transfer_count(COUNT_W'(DIRECTED_COUNTS[i]));
      for (int i = 0; i < RANDOM_ITEMS; i++) begin
         if (i == 40) begin
            hold_requests++;
            transfer_count(COUNT_W'(MAX_COUNT));
         end
         if (i == 100) drain_primes();
         transfer_count(random_count());
      end
      drain_primes();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && primes_pending == 0) begin
         $display("** first_primes_generator: PASSED **");
      end else begin
         $display("** first_primes_generator: FAILED **");
      end
      $finish;
   end

   initial begin
      #200_000_000;
      $display("** first_primes_generator: FAILED **");
      $finish;
   end

endmodule

// File: first_primes_generator.f
+incdir+design
design/fpg_pkg.sv
design/fpg_rem.sv
design/first_primes_generator.sv
verif/first_primes_generator_checker.sv
verif/tb_first_primes_generator.sv
